// ===== src/m3i_pkg.sv =====
// Package for the 3x3 matrix inverse pipeline.
// Holds the element width, the input and result beat types and the cofactor index table.
// No dependencies.
package m3i_pkg;

  localparam int DW = 24;

  typedef struct packed {
    logic signed [DW-1:0] a00;
    logic signed [DW-1:0] a01;
    logic signed [DW-1:0] a02;
    logic signed [DW-1:0] a10;
    logic signed [DW-1:0] a11;
    logic signed [DW-1:0] a12;
    logic signed [DW-1:0] a20;
    logic signed [DW-1:0] a21;
    logic signed [DW-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] b00;
    logic signed [DW-1:0] b01;
    logic signed [DW-1:0] b02;
    logic signed [DW-1:0] b10;
    logic signed [DW-1:0] b11;
    logic signed [DW-1:0] b12;
    logic signed [DW-1:0] b20;
    logic signed [DW-1:0] b21;
    logic signed [DW-1:0] b22;
    logic                 singular;
    logic                 overflow;
  } out_t;

  // Inverse element i gets cofactor a[P]*a[Q] - a[R]*a[S], elements in row-major order.
  localparam int COF_IDX [9][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

endpackage

// ===== src/matrix3x3_inverse_top.sv =====
// Top level of the 3x3 matrix inverse: cofactors, determinant and a pipelined divider.
// Depends on m3i_pkg for the beat types and the cofactor index table.
//
//   channel  ports                          beat
//   input    in_valid, in_stall, in_data    m3i_pkg::in_t, one matrix
//   result   out_valid, out_stall, out_data m3i_pkg::out_t, inverse and flags
//
// The divider is a restoring one with one quotient bit per stage; one matrix can enter every
// cycle unless the pipeline is full and the result is stalled.
// Every stage loads when it is empty or its successor loads, so bubbles are squeezed out
// and a stalled result does not block items upstream until the pipeline is full.
// Synchronous active-low reset clears only the valid bits.
module matrix3x3_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  m3i_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output m3i_pkg::out_t  out_data
);

  localparam int DW   = m3i_pkg::DW;
  localparam int PW   = 2 * DW;
  localparam int CW   = 2 * DW + 1;
  localparam int LW   = 2 * DW + 2;
  localparam int DPW  = CW + DW;
  localparam int DETW = DPW + 2;
  localparam int RW   = 4 * DW + 2 * FRAC_BITS + 2;
  localparam int NDIV = DW + 1;
  localparam int NST  = 5 + NDIV;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  logic           out_valid_r;
  m3i_pkg::out_t  out_data_r;

  assign en[NST] = !out_valid_r || !out_stall;
  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_en
      assign en[s] = !v_r[s] || en[s+1];
    end
  endgenerate
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[i-1];
        end
      end
      if (en[NST]) begin
        out_valid_r <= v_r[NST-1];
      end
    end
  end

  logic signed [DW-1:0] a_in [9];
  assign a_in[0] = in_data.a00;
  assign a_in[1] = in_data.a01;
  assign a_in[2] = in_data.a02;
  assign a_in[3] = in_data.a10;
  assign a_in[4] = in_data.a11;
  assign a_in[5] = in_data.a12;
  assign a_in[6] = in_data.a20;
  assign a_in[7] = in_data.a21;
  assign a_in[8] = in_data.a22;

  // Stage 0: the eighteen cofactor products.
  logic signed [PW-1:0]  prod_r [9][2];
  logic signed [DW-1:0]  a0_r [3];
  // Stage 1: cofactors.
  logic signed [CW-1:0]  cof1_r [9];
  logic signed [DW-1:0]  a1_r [3];
  // Stage 2: determinant terms, cofactors 0, 3, 6 split into signed high and unsigned low parts.
  logic signed [PW-1:0]  dph_r [3];
  logic signed [LW-1:0]  dpl_r [3];
  logic signed [CW-1:0]  cof2_r [9];
  // Stage 3: determinant.
  logic signed [DETW-1:0] det_r;
  logic signed [CW-1:0]   cof3_r [9];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 9; i++) begin
        prod_r[i][0] <= PW'(a_in[m3i_pkg::COF_IDX[i][0]]) * PW'(a_in[m3i_pkg::COF_IDX[i][1]]);
        prod_r[i][1] <= PW'(a_in[m3i_pkg::COF_IDX[i][2]]) * PW'(a_in[m3i_pkg::COF_IDX[i][3]]);
      end
      for (int i = 0; i < 3; i++) a0_r[i] <= a_in[i];
    end
    if (en[1]) begin
      for (int i = 0; i < 9; i++) cof1_r[i] <= CW'(prod_r[i][0]) - CW'(prod_r[i][1]);
      a1_r <= a0_r;
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        dph_r[i] <= PW'($signed(cof1_r[3*i][CW-1:DW+1])) * PW'(a1_r[i]);
        dpl_r[i] <= LW'($signed({1'b0, cof1_r[3*i][DW:0]})) * LW'(a1_r[i]);
      end
      cof2_r <= cof1_r;
    end
    if (en[3]) begin
      det_r  <= (DETW'(dph_r[0]) <<< (DW + 1)) + DETW'(dpl_r[0])
              + (DETW'(dph_r[1]) <<< (DW + 1)) + DETW'(dpl_r[1])
              + (DETW'(dph_r[2]) <<< (DW + 1)) + DETW'(dpl_r[2]);
      cof3_r <= cof2_r;
    end
  end

  // Divider. Index 0 is the setup stage; index j holds the remainder after quotient
  // bit DW-j+1. The first step only tells whether the quotient reaches 2^DW.
  logic [RW-1:0]   rem_r  [0:NDIV][9];
  logic [NDIV-1:0] quo_r  [0:NDIV][9];
  logic            neg_r  [0:NDIV][9];
  logic [DETW:0]   den_r  [0:NDIV];
  logic            sing_r [0:NDIV];

  logic [DETW-1:0] dabs;
  assign dabs = det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 9; i++) begin
        // Numerator carries the rounding term: (2*|c|*2^2F + |det|) / (2*|det|).
        rem_r[0][i] <= (RW'(cof3_r[i][CW-1] ? CW'(-cof3_r[i]) : CW'(cof3_r[i]))
                        << (2 * FRAC_BITS + 1)) + RW'(dabs);
        quo_r[0][i] <= '0;
        neg_r[0][i] <= cof3_r[i][CW-1] ^ det_r[DETW-1];
      end
      den_r[0]  <= {dabs, 1'b0};
      sing_r[0] <= (det_r == '0);
    end
  end

  genvar j, e;
  generate
    for (j = 1; j <= NDIV; j++) begin : g_div
      localparam int K = DW - j + 1;
      logic [RW-1:0] sub;
      assign sub = RW'(den_r[j-1]) << K;
      for (e = 0; e < 9; e++) begin : g_el
        logic ge;
        assign ge = (rem_r[j-1][e] >= sub);
        always_ff @(posedge clk) begin
          if (en[4+j]) begin
            rem_r[j][e] <= ge ? rem_r[j-1][e] - sub : rem_r[j-1][e];
            quo_r[j][e] <= {quo_r[j-1][e][NDIV-2:0], ge};
            neg_r[j][e] <= neg_r[j-1][e];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[4+j]) begin
          den_r[j]  <= den_r[j-1];
          sing_r[j] <= sing_r[j-1];
        end
      end
    end
  endgenerate

  // Final rounding already done; saturate and negate, or give zeros for a singular matrix.
  localparam logic [DW:0] PMAX = {2'b00, {(DW-1){1'b1}}};
  localparam logic [DW:0] NMAX = {2'b01, {(DW-1){1'b0}}};
  logic [DW-1:0] res [9];
  logic [8:0]    sat;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (neg_r[NDIV][i]) begin
        sat[i] = quo_r[NDIV][i] > NMAX;
        res[i] = sat[i] ? NMAX[DW-1:0] : DW'(-quo_r[NDIV][i]);
      end else begin
        sat[i] = quo_r[NDIV][i] > PMAX;
        res[i] = sat[i] ? PMAX[DW-1:0] : quo_r[NDIV][i][DW-1:0];
      end
      if (sing_r[NDIV]) begin
        res[i] = '0;
        sat[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      out_data_r.b00 <= res[0];
      out_data_r.b01 <= res[1];
      out_data_r.b02 <= res[2];
      out_data_r.b10 <= res[3];
      out_data_r.b11 <= res[4];
      out_data_r.b12 <= res[5];
      out_data_r.b20 <= res[6];
      out_data_r.b21 <= res[7];
      out_data_r.b22 <= res[8];
      out_data_r.singular <= sing_r[NDIV];
      out_data_r.overflow <= |sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/matrix3x3_inverse_checker.sv =====
// Checker for the 3x3 matrix inverse: watches both channels, predicts each inverse
// from the accepted matrix and compares it field by field. Depends on m3i_pkg.
module matrix3x3_inverse_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  m3i_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  m3i_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count,
  output int            result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;

  m3i_pkg::out_t inverse_q[$];

  function automatic m3i_pkg::out_t invert_matrix(m3i_pkg::in_t m);
    logic signed [m3i_pkg::DW-1:0] a[9];
    logic signed [63:0] c[9];
    logic signed [127:0] det, dabs, num, q, pmax;
    logic neg;
    logic signed [m3i_pkg::DW-1:0] e[9];
    m3i_pkg::out_t r;
    a = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    for (int i = 0; i < 9; i++)
      c[i] = 64'(a[m3i_pkg::COF_IDX[i][0]]) * 64'(a[m3i_pkg::COF_IDX[i][1]])
           - 64'(a[m3i_pkg::COF_IDX[i][2]]) * 64'(a[m3i_pkg::COF_IDX[i][3]]);
    det = 128'(c[0]) * 128'(a[0]) + 128'(c[3]) * 128'(a[1]) + 128'(c[6]) * 128'(a[2]);
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dabs = det < 0 ? -det : det;
    pmax = (128'sd1 <<< (m3i_pkg::DW - 1)) - 1;
    for (int i = 0; i < 9; i++) begin
      num = 128'(c[i] < 0 ? -c[i] : c[i]) <<< (2 * FRAC);
      neg = (c[i] < 0) != (det < 0);
      // Round to nearest, ties away from zero, on the magnitude.
      q = (2 * num + dabs) / (2 * dabs);
      if (neg) begin
        if (q > pmax + 1) begin
          q = pmax + 1;
          r.overflow = 1'b1;
        end
        e[i] = m3i_pkg::DW'(-q);
      end else begin
        if (q > pmax) begin
          q = pmax;
          r.overflow = 1'b1;
        end
        e[i] = m3i_pkg::DW'(q);
      end
    end
    {r.b00, r.b01, r.b02, r.b10, r.b11, r.b12, r.b20, r.b21, r.b22} =
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: result %0d field %s got %0d want %0d",
             $realtime, result_count, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  assign pending_count = inverse_q.size();

  always @(posedge clk) begin
    m3i_pkg::out_t w;
    if (rst_n && in_valid && !in_stall) inverse_q.push_back(invert_matrix(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        w = inverse_q.pop_front();
        if (out_data.b00 != w.b00) report_mismatch("b00", out_data.b00, w.b00);
        if (out_data.b01 != w.b01) report_mismatch("b01", out_data.b01, w.b01);
        if (out_data.b02 != w.b02) report_mismatch("b02", out_data.b02, w.b02);
        if (out_data.b10 != w.b10) report_mismatch("b10", out_data.b10, w.b10);
        if (out_data.b11 != w.b11) report_mismatch("b11", out_data.b11, w.b11);
        if (out_data.b12 != w.b12) report_mismatch("b12", out_data.b12, w.b12);
        if (out_data.b20 != w.b20) report_mismatch("b20", out_data.b20, w.b20);
        if (out_data.b21 != w.b21) report_mismatch("b21", out_data.b21, w.b21);
        if (out_data.b22 != w.b22) report_mismatch("b22", out_data.b22, w.b22);
        if (out_data.singular !== w.singular)
          report_mismatch("singular", out_data.singular, w.singular);
        if (out_data.overflow !== w.overflow)
          report_mismatch("overflow", out_data.overflow, w.overflow);
      end
      result_count++;
    end
  end
endmodule

// ===== verif/matrix3x3_inverse_top_tb.sv =====
// Testbench top for the 3x3 matrix inverse: drives matrices with random idling and
// result stalls, and gives the verdict. Depends on m3i_pkg, the top and the checker module.
module matrix3x3_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 31;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS = 750;
  localparam logic signed [m3i_pkg::DW-1:0] ONE = 24'sh010000;
  localparam logic signed [m3i_pkg::DW-1:0] MAXV = 24'sh7fffff;
  localparam logic signed [m3i_pkg::DW-1:0] MINV = 24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  m3i_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  m3i_pkg::out_t out_data;
  int fail_count, pending_count, result_count;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit stall_on = 1'b1;

  always #5 clk = ~clk;

  matrix3x3_inverse_top u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  matrix3x3_inverse_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .pending_count, .result_count
  );

  // Result stalls come in bursts; none in the last part of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (calm || !stall_on) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 99) == 0) stall_on = !stall_on;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("matrix3x3_inverse_top regression: fail");
      $finish;
    end
  end

  function automatic logic signed [m3i_pkg::DW-1:0] pick_element();
    case ($urandom_range(0, 5))
      0: return m3i_pkg::DW'($urandom);
      1: return m3i_pkg::DW'($signed($urandom_range(0, 2 * 65536)) - 65536);
      2: return ($urandom_range(0, 1) ? MAXV : MINV);
      3: return m3i_pkg::DW'($signed($urandom_range(0, 512)) - 256);
      default: return m3i_pkg::DW'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic m3i_pkg::in_t pick_matrix();
    m3i_pkg::in_t m;
    m = {pick_element(), pick_element(), pick_element(), pick_element(), pick_element(),
         pick_element(), pick_element(), pick_element(), pick_element()};
    case ($urandom_range(0, 9))
      0: begin
        m.a10 = m.a00;
        m.a11 = m.a01;
        m.a12 = m.a02;
      end
      1: m = {ONE, 24'sd0, 24'sd0, 24'sd0, pick_element(), 24'sd0, 24'sd0, 24'sd0,
              pick_element()};
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_matrix(m3i_pkg::in_t m);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    m3i_pkg::in_t directed[$];
    int guard;
    directed.push_back({ONE, 24'sd0, 24'sd0, 24'sd0, ONE, 24'sd0, 24'sd0, 24'sd0, ONE});
    directed.push_back('0);
    directed.push_back({9{ONE}});
    directed.push_back({MAXV, 24'sd0, 24'sd0, 24'sd0, MAXV, 24'sd0, 24'sd0, 24'sd0, MAXV});
    directed.push_back({MINV, 24'sd0, 24'sd0, 24'sd0, MINV, 24'sd0, 24'sd0, 24'sd0, MINV});
    directed.push_back({24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0,
                        24'sd1});
    directed.push_back({-ONE, 24'sd0, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, ONE});
    directed.push_back({24'sd3, 24'sd0, 24'sd0, 24'sd0, 24'sd3, 24'sd0, 24'sd0, 24'sd0,
                        24'sd3});
    directed.push_back({MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV});
    directed.push_back({MINV, MAXV, 24'sd0, MAXV, MINV, MAXV, 24'sd0, MAXV, MINV});
    directed.push_back({24'sd2 * ONE, ONE, 24'sd0, ONE, 24'sd2 * ONE, ONE, 24'sd0, ONE,
                        24'sd2 * ONE});
    directed.push_back({9{24'hffffff}});
    directed.push_back({24'h555555, 24'haaaaaa, 24'h123456, 24'hedcba9, 24'h0f0f0f,
                        24'hf0f0f0, 24'h333333, 24'hcccccc, 24'h7f00ff});
    directed.push_back({24'haaaaaa, 24'h555555, 24'hedcba9, 24'h123456, 24'hf0f0f0,
                        24'h0f0f0f, 24'hcccccc, 24'h333333, 24'h80ff00});

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_matrix(directed[i]);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS - 100) calm = 1'b1;
      send_matrix(pick_matrix());
    end
    in_valid <= 1'b0;
    guard = 0;
    while (pending_count != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d matrices: identity, singular, extreme, rounding and random cases",
             directed.size() + RANDOM_BEATS);
    $display("checked %0d inverse beats with bursty idling and result stalls", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("matrix3x3_inverse_top regression: pass");
    end else begin
      $display("matrix3x3_inverse_top regression: fail");
    end
    $finish;
  end
endmodule
